// ----- rtl/core/dlbh_pkg.sv -----
// ----------------------------------------------------------------------------
// dlbh_pkg
// Shared types and constants of the two-lane 128-bit byte hash: payload
// structs, datapath commands and hash constants.
// ----------------------------------------------------------------------------
package dlbh_pkg;

  localparam logic [63:0] LANE_ONE_INIT = 64'hcbf29ce484222325;
  localparam logic [63:0] LANE_ONE_MUL  = 64'h00000100000001b3;
  localparam logic [63:0] LANE_TWO_INIT = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MUL_CONST_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MUL_CONST_B   = 64'h94d049bb133111eb;

  localparam int unsigned FNV_SHIFT  = 40;
  localparam int unsigned ROT_LEFT   = 13;
  localparam int unsigned FIN_SHIFT1 = 30;
  localparam int unsigned FIN_SHIFT2 = 27;
  localparam int unsigned FIN_SHIFT3 = 31;

  typedef struct packed {
    logic        mode;
    logic [63:0] payload;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_item_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_ROUND,
    DP_MUL,
    DP_SUM_LANE,
    DP_FIN_LANE_ONE,
    DP_FIN_LANE_TWO,
    DP_SUM_MID,
    DP_SUM_HIGH,
    DP_SUM_LOW
  } dp_op_t;

  typedef enum logic {
    MUL_SEL_A,
    MUL_SEL_B
  } mul_sel_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t mul_sel;
  } dp_cmd_t;

endpackage

// ----- rtl/core/dlbh_datapath.sv -----
// ----------------------------------------------------------------------------
// dlbh_datapath
// Lane registers, byte shifter, split 64-bit constant multiplier and digest
// output register, driven one command per cycle.
// ----------------------------------------------------------------------------
module dlbh_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  dlbh_pkg::dp_cmd_t  cmd,
  input  logic [63:0]        payload,
  output dlbh_pkg::out_item_t digest
);

  logic [63:0] lane_one_r, lane_one_nxt;
  logic [63:0] lane_two_r, lane_two_nxt;
  logic [63:0] word_r,     word_nxt;
  logic [63:0] op_r,       op_nxt;
  logic [63:0] pp_ll_r;
  logic [31:0] pp_lh_r;
  logic [31:0] pp_hl_r;
  logic [63:0] dig_hi_r,   dig_hi_nxt;
  logic [63:0] dig_lo_r,   dig_lo_nxt;

  logic [63:0] mul_const;
  logic [63:0] product;
  logic [31:0] cross_sum;
  logic [63:0] fnv_x;
  logic [63:0] fnv_next;
  logic [63:0] term;
  logic [63:0] mixed;
  logic [63:0] rotated;

  always_comb begin
    mul_const = (cmd.mul_sel == dlbh_pkg::MUL_SEL_B) ? dlbh_pkg::MUL_CONST_B
                                                       : dlbh_pkg::MUL_CONST_A;
    cross_sum = pp_lh_r + pp_hl_r;
    product   = pp_ll_r + {cross_sum, 32'd0};

    fnv_x    = lane_one_r ^ {56'd0, word_r[7:0]};
    fnv_next = (fnv_x << dlbh_pkg::FNV_SHIFT)
             + (fnv_x * {55'd0, dlbh_pkg::LANE_ONE_MUL[8:0]});

    term    = {56'd0, word_r[7:0]} + dlbh_pkg::LANE_TWO_INIT
            + (lane_two_r << 6) + (lane_two_r >> 2);
    mixed   = lane_two_r ^ term;
    rotated = {mixed[63-dlbh_pkg::ROT_LEFT:0], mixed[63:64-dlbh_pkg::ROT_LEFT]};
  end

  always_comb begin
    lane_one_nxt = lane_one_r;
    lane_two_nxt = lane_two_r;
    word_nxt     = word_r;
    op_nxt       = op_r;
    dig_hi_nxt   = dig_hi_r;
    dig_lo_nxt   = dig_lo_r;
    unique case (cmd.op)
      dlbh_pkg::DP_NOP,
      dlbh_pkg::DP_MUL: begin
      end
      dlbh_pkg::DP_LOAD: begin
        word_nxt = payload;
      end
      dlbh_pkg::DP_ROUND: begin
        lane_one_nxt = fnv_next;
        op_nxt       = rotated;
        word_nxt     = word_r >> 8;
      end
      dlbh_pkg::DP_SUM_LANE: begin
        lane_two_nxt = product;
      end
      dlbh_pkg::DP_FIN_LANE_ONE: begin
        op_nxt = lane_one_r ^ (lane_one_r >> dlbh_pkg::FIN_SHIFT1);
      end
      dlbh_pkg::DP_FIN_LANE_TWO: begin
        op_nxt = lane_two_r ^ (lane_two_r >> dlbh_pkg::FIN_SHIFT1);
      end
      dlbh_pkg::DP_SUM_MID: begin
        op_nxt = product ^ (product >> dlbh_pkg::FIN_SHIFT2);
      end
      dlbh_pkg::DP_SUM_HIGH: begin
        dig_hi_nxt = product ^ (product >> dlbh_pkg::FIN_SHIFT3);
      end
      dlbh_pkg::DP_SUM_LOW: begin
        dig_lo_nxt   = product ^ (product >> dlbh_pkg::FIN_SHIFT3);
        lane_one_nxt = dlbh_pkg::LANE_ONE_INIT;
        lane_two_nxt = dlbh_pkg::LANE_TWO_INIT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_one_r <= dlbh_pkg::LANE_ONE_INIT;
      lane_two_r <= dlbh_pkg::LANE_TWO_INIT;
    end else begin
      lane_one_r <= lane_one_nxt;
      lane_two_r <= lane_two_nxt;
    end
  end

  // word, operand and digest registers, and the partial products of the low 64 bits, registered ahead of the final add
  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    op_r     <= op_nxt;
    dig_hi_r <= dig_hi_nxt;
    dig_lo_r <= dig_lo_nxt;
    if (cmd.op == dlbh_pkg::DP_MUL) begin
      pp_ll_r <= {32'd0, op_r[31:0]} * {32'd0, mul_const[31:0]};
      pp_lh_r <= 32'(op_r[31:0] * mul_const[63:32]);
      pp_hl_r <= 32'(op_r[63:32] * mul_const[31:0]);
    end
  end

  assign digest.digest_high = dig_hi_r;
  assign digest.digest_low  = dig_lo_r;

endmodule

// ----- rtl/core/dlbh_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlbh_ctrl
// Sequencer of the byte hash: takes a transaction, steps the datapath through
// the byte rounds and the two lane finalisations, and owns the result valid.
// ----------------------------------------------------------------------------
module dlbh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dlbh_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_RPP,
    S_RSUM,
    S_FSTART,
    S_FPP,
    S_FMID,
    S_FEND
  } state_t;

  state_t     state_r,     state_nxt;
  logic [2:0] cnt_r,       cnt_nxt;
  logic       last_r,      last_nxt;
  logic       lane_r,      lane_nxt;
  logic       stage_r,     stage_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    lane_nxt      = lane_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = dlbh_pkg::DP_NOP;
    cmd.mul_sel   = dlbh_pkg::MUL_SEL_A;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = dlbh_pkg::DP_LOAD;
          cnt_nxt   = in_mode ? 3'd7 : 3'd0;
          last_nxt  = in_last;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.op    = dlbh_pkg::DP_ROUND;
        state_nxt = S_RPP;
      end
      S_RPP: begin
        cmd.op    = dlbh_pkg::DP_MUL;
        state_nxt = S_RSUM;
      end
      S_RSUM: begin
        cmd.op = dlbh_pkg::DP_SUM_LANE;
        if (cnt_r != 3'd0) begin
          cnt_nxt   = cnt_r - 3'd1;
          state_nxt = S_ROUND;
        end else if (last_r) begin
          lane_nxt  = 1'b0;
          state_nxt = S_FSTART;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FSTART: begin
        if (lane_r) begin
          cmd.op    = dlbh_pkg::DP_FIN_LANE_TWO;
          stage_nxt = 1'b0;
          state_nxt = S_FPP;
        end else if (slot_free) begin
          cmd.op    = dlbh_pkg::DP_FIN_LANE_ONE;
          stage_nxt = 1'b0;
          state_nxt = S_FPP;
        end
      end
      S_FPP: begin
        cmd.op      = dlbh_pkg::DP_MUL;
        cmd.mul_sel = stage_r ? dlbh_pkg::MUL_SEL_B : dlbh_pkg::MUL_SEL_A;
        state_nxt   = stage_r ? S_FEND : S_FMID;
      end
      S_FMID: begin
        cmd.op    = dlbh_pkg::DP_SUM_MID;
        stage_nxt = 1'b1;
        state_nxt = S_FPP;
      end
      S_FEND: begin
        if (lane_r) begin
          cmd.op        = dlbh_pkg::DP_SUM_LOW;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.op    = dlbh_pkg::DP_SUM_HIGH;
          lane_nxt  = 1'b1;
          state_nxt = S_FSTART;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 3'd0;
      last_r      <= 1'b0;
      lane_r      <= 1'b0;
      stage_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      lane_r      <= lane_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts_round: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_ROUND))
    else $error("accepted transaction did not start a round");

  a_fin_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FSTART) |-> (cnt_r == 3'd0 && last_r))
    else $error("finalisation entered with rounds outstanding");

  a_slot_free_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEND && lane_r) |-> !out_valid_r)
    else $error("digest overwritten while previous result pending");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FEND && lane_r))
    else $error("result valid raised outside the emit step");

endmodule

// ----- rtl/core/dual_lane_byte_hash_128_unit.sv -----
// ----------------------------------------------------------------------------
// dual_lane_byte_hash_128_unit
// Two-lane 128-bit message hash: FNV-1a 64 and a rotate-multiply lane, both
// finished with the splitmix64 finaliser on the last transaction.
// ----------------------------------------------------------------------------
// Each absorbed byte passes the shared 64-bit constant multiplier as mix,
// partial products and sum; a byte item absorbs its low payload byte, a word
// item all eight bytes, and no new item is taken until they are done. An item
// with last set adds the finalisation of both lanes in turn, and starts only
// once the previous digest has been taken; the digest then waits in the output
// register while the next transaction is absorbed.
module dual_lane_byte_hash_128_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlbh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dlbh_pkg::out_item_t out_data
);

  dlbh_pkg::dp_cmd_t cmd;

  dlbh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dlbh_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .payload (in_data.payload),
    .digest  (out_data)
  );

endmodule
